// ----- rtl/mfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MFU cache package
// Word types, table entry type and the probe record that walks the cell chain.
// ----------------------------------------------------------------------------
package mfu_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam int POS_W           = 8;     // holds a cell position up to 255
   localparam int CAP_W           = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [15:0] COUNT_ONE = 16'd1;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic [15:0]        count;
   } entry_type;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic               hit;
      logic [POS_W-1:0]   hit_pos;
      logic signed [31:0] hit_value;
      logic [15:0]        hit_count;
      logic               best_valid;
      logic [POS_W-1:0]   best_pos;
      logic [15:0]        best_count;
      logic signed [31:0] best_key;
   } probe_type;

   typedef struct packed {
      logic             enable;
      logic [POS_W-1:0] target;
   } update_type;

endpackage
`default_nettype wire

// ----- rtl/mfu_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MFU cache cell
// One table entry at a fixed recency position, plus one stage of the probe.
// ----------------------------------------------------------------------------
module mfu_cell #(
   parameter int IDX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mfu_pkg::entry_type  prev_entry,
   input  wire mfu_pkg::update_type upd,
   input  wire mfu_pkg::probe_type  probe_in,
   output      mfu_pkg::entry_type  entry_out,
   output      mfu_pkg::probe_type  probe_out
);
   import mfu_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

   entry_type entry_ff, entry_in;
   probe_type probe_ff, probe_in_nx;

   always_comb begin
      probe_in_nx = probe_in;
      if (entry_ff.valid && entry_ff.key == probe_in.key) begin
         probe_in_nx.hit       = 1'b1;
         probe_in_nx.hit_pos   = MY_POS;
         probe_in_nx.hit_value = entry_ff.value;
         probe_in_nx.hit_count = entry_ff.count;
      end
      // Later positions are older, so ties go to the later cell.
      if (entry_ff.valid && (!probe_in.best_valid || entry_ff.count >= probe_in.best_count))
      begin
         probe_in_nx.best_valid = 1'b1;
         probe_in_nx.best_pos   = MY_POS;
         probe_in_nx.best_count = entry_ff.count;
         probe_in_nx.best_key   = entry_ff.key;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (upd.enable && MY_POS <= upd.target) begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff <= probe_in_nx;
   end

   assign entry_out = entry_ff;
   assign probe_out = probe_ff;

endmodule
`default_nettype wire

// ----- rtl/mfu_replacement_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MFU replacement cache
// Fully associative key/value cache that evicts the most frequently used entry.
// ----------------------------------------------------------------------------
// The table is a chain of ENTRIES cells kept in recency order: cell 0 holds the
// newest entry and the valid entries always fill the front of the chain, so a
// cell's position is its age rank. Each request word is registered at the head
// of the chain, then a probe record walks the chain one cell per cycle, taking
// the key match and the oldest entry of highest use count. The update state
// then applies the update: every cell at or before the target position takes
// its neighbor's entry and cell 0 takes the touched or inserted entry. No new
// request is taken until the update is done. The response word sits in an
// output register, so a stalled response only holds the update of the following
// word. Capacity is written through csr_wr_en/csr_wr_data; the user must write it
// only while the cache is idle, as the block itself does not enforce it. Values
// above ENTRIES act as ENTRIES and zero turns every put into a plain lookup.
module mfu_replacement_cache #(
   parameter int ENTRIES = mfu_pkg::DEFAULT_ENTRIES
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire mfu_pkg::req_type         req_data,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      mfu_pkg::rsp_type         rsp_data,
   input  wire logic                     csr_wr_en,
   input  wire logic [mfu_pkg::CAP_W-1:0] csr_wr_data
);
   import mfu_pkg::*;

   localparam int UW = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] cnt_ff, cnt_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [CAP_W-1:0] cap_ff;
   probe_type        pr0_ff, pr0_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   probe_type  probe [ENTRIES+1];
   entry_type  ent   [ENTRIES];
   entry_type  fill;
   update_type upd;
   probe_type  pl;

   logic accept, upd_go, full, cap_zero, is_put, evict;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign pl       = probe[ENTRIES];
   assign cap_zero = (cap_ff == '0);
   assign is_put   = (pl.cmd == CMD_PUT);
   assign full     = (32'(used_ff) >= 32'(cap_ff)) || (32'(used_ff) == 32'(ENTRIES));
   assign upd_go   = (state_ff == ST_UPDATE) && !(rsp_valid_ff && rsp_stall);
   assign evict    = !pl.hit && is_put && !cap_zero && full;

   // Entry that lands in cell 0: the touched hit or the new key.
   always_comb begin
      fill.valid = 1'b1;
      fill.key   = pl.key;
      if (pl.hit) begin
         fill.value = is_put ? pl.value : pl.hit_value;
         fill.count = (pl.hit_count == COUNT_MAX) ? pl.hit_count : pl.hit_count + 16'd1;
      end else begin
         fill.value = pl.value;
         fill.count = COUNT_ONE;
      end
   end

   always_comb begin
      upd.enable = upd_go && (pl.hit ? (!is_put || !cap_zero) : (is_put && !cap_zero));
      if (pl.hit) begin
         upd.target = pl.hit_pos;
      end else if (full) begin
         upd.target = pl.best_pos;
      end else begin
         upd.target = POS_W'(used_ff);
      end
   end

   assign probe[0] = pr0_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type prev;
      if (i == 0) begin : g_head
         assign prev = fill;
      end else begin : g_body
         assign prev = ent[i-1];
      end
      mfu_cell #(.IDX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_entry (prev),
         .upd        (upd),
         .probe_in   (probe[i]),
         .entry_out  (ent[i]),
         .probe_out  (probe[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == POS_W'(ENTRIES - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (upd_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      used_in = used_ff;
      if (upd_go && !pl.hit && is_put && !cap_zero && !full) begin
         used_in = used_ff + 1'b1;
      end
   end

   // The probe record starts empty and carries the request fields.
   always_comb begin
      pr0_in       = '0;
      pr0_in.cmd   = req_data.cmd;
      pr0_in.key   = req_data.key;
      pr0_in.value = req_data.value;
   end

   always_comb begin
      rsp_in.hit         = pl.hit;
      rsp_in.read_value  = pl.hit ? pl.hit_value : 32'sd0;
      rsp_in.evicted     = evict;
      rsp_in.evicted_key = evict ? pl.best_key : 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         used_ff      <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         used_ff  <= used_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (upd_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pr0_ff <= pr0_in;
      end
      if (upd_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/mfu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MFU cache port checker
// Checks on what the cache shows at its ports, bound to the top level.
// ----------------------------------------------------------------------------
module mfu_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire mfu_pkg::rsp_type          rsp_data
);
   import mfu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a word is still in the chain");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> !rsp_data.hit)
      else $error("eviction reported on a hit");

   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.evicted |-> rsp_data.evicted_key == 32'sd0)
      else $error("evicted key nonzero without eviction");

   a_miss_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.read_value == 32'sd0)
      else $error("read value nonzero on a miss");

endmodule

bind mfu_replacement_cache mfu_checker u_mfu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data)
);
`default_nettype wire
